// File: design/cbf_pkg.sv
// Shared types and constants of the cassette block framer.
`default_nettype none

package cbf_pkg;

    localparam int NAME_FIELD    = 11;
    localparam int NAME_LEN_DEF  = 11;
    localparam int BLOCK_MAX_DEF = 254;
    localparam int CMDQ_DEPTH    = 2;
    localparam int SYNC_ONES     = 16;

    localparam logic [1:0] OP_NAME  = 2'd0;
    localparam logic [1:0] OP_BLOCK = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [7:0] SYNC_ONE     = 8'h01;
    localparam logic [7:0] SYNC_A       = 8'h3C;
    localparam logic [7:0] SYNC_B       = 8'h5A;
    localparam logic [7:0] PAD_CHAR     = 8'h20;
    localparam logic [7:0] HDR_TYPE     = 8'h00;
    localparam logic [7:0] HDR_LEN      = 8'h10;
    localparam logic [7:0] TAIL_A       = 8'h02;
    localparam logic [7:0] TAIL_ZERO    = 8'h00;
    localparam logic [7:0] BLK_TYPE     = 8'h01;
    localparam logic [7:0] FOOT_TYPE    = 8'hFF;
    localparam logic [7:0] NAME_SUM_RST = 8'(NAME_FIELD * 32);

    typedef logic [NAME_FIELD-1:0][7:0] t_name;

    typedef enum logic [1:0] {
        KIND_BLOCK,
        KIND_DATA,
        KIND_FOOT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       hdr;
        logic       sum_flag;
        logic [7:0] value;
        logic [7:0] chk;
        t_name      name;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/cbf_front.sv
// Front end: accepts items, checks order, keeps file state and issues commands.
`default_nettype none

module cbf_front #(
    parameter int NAME_LEN  = cbf_pkg::NAME_LEN_DEF,
    parameter int BLOCK_MAX = cbf_pkg::BLOCK_MAX_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_q_full,
    input  wire logic [1:0]    i_opcode,
    input  wire logic [7:0]    i_value,
    output logic               o_full,
    output logic               o_cmd_push,
    output cbf_pkg::t_cmd      o_cmd
);
    import cbf_pkg::*;

    t_name      r_name, n_name;
    logic [3:0] r_name_cnt, n_name_cnt;
    logic [7:0] r_name_sum, n_name_sum;
    logic       r_hdr_sent, n_hdr_sent;
    logic [7:0] r_left, n_left;
    logic [7:0] r_bsum, n_bsum;
    logic       accept;
    logic [7:0] hdr_chk;
    logic [7:0] data_sum;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign hdr_chk  = 8'h00 - (r_name_sum + TAIL_A);
    assign data_sum = r_bsum + i_value;

    always_comb begin
        n_name         = r_name;
        n_name_cnt     = r_name_cnt;
        n_name_sum     = r_name_sum;
        n_hdr_sent     = r_hdr_sent;
        n_left         = r_left;
        n_bsum         = r_bsum;
        o_cmd_push     = 1'b0;
        o_cmd.kind     = KIND_DATA;
        o_cmd.hdr      = !r_hdr_sent;
        o_cmd.sum_flag = 1'b0;
        o_cmd.value    = i_value;
        o_cmd.chk      = hdr_chk;
        o_cmd.name     = r_name;
        if (accept) begin
            case (i_opcode)
                OP_NAME: begin
                    if (!r_hdr_sent && (r_name_cnt < 4'(NAME_LEN))) begin
                        n_name[r_name_cnt] = i_value;
                        n_name_cnt         = r_name_cnt + 4'd1;
                        n_name_sum         = r_name_sum + i_value - PAD_CHAR;
                    end
                end
                OP_BLOCK: begin
                    if ((r_left == 8'd0) && (i_value != 8'd0)
                        && (i_value <= 8'(BLOCK_MAX))) begin
                        o_cmd_push  = 1'b1;
                        o_cmd.kind  = KIND_BLOCK;
                        o_cmd.value = i_value + 8'd2;
                        n_hdr_sent  = 1'b1;
                        n_left      = i_value;
                        n_bsum      = 8'd0;
                    end
                end
                OP_DATA: begin
                    if (r_left != 8'd0) begin
                        o_cmd_push     = 1'b1;
                        o_cmd.kind     = KIND_DATA;
                        o_cmd.hdr      = 1'b0;
                        o_cmd.sum_flag = (r_left == 8'd1);
                        o_cmd.chk      = 8'h00 - data_sum;
                        n_left         = r_left - 8'd1;
                        n_bsum         = (r_left == 8'd1) ? 8'd0 : data_sum;
                    end
                end
                OP_END: begin
                    if (r_left == 8'd0) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = KIND_FOOT;
                        n_name     = {NAME_FIELD{PAD_CHAR}};
                        n_name_cnt = 4'd0;
                        n_name_sum = NAME_SUM_RST;
                        n_hdr_sent = 1'b0;
                        n_left     = 8'd0;
                        n_bsum     = 8'd0;
                    end
                end
                default: begin
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name     <= {NAME_FIELD{PAD_CHAR}};
            r_name_cnt <= 4'd0;
            r_name_sum <= NAME_SUM_RST;
            r_hdr_sent <= 1'b0;
            r_left     <= 8'd0;
            r_bsum     <= 8'd0;
        end else begin
            r_name     <= n_name;
            r_name_cnt <= n_name_cnt;
            r_name_sum <= n_name_sum;
            r_hdr_sent <= n_hdr_sent;
            r_left     <= n_left;
            r_bsum     <= n_bsum;
        end
    end

endmodule

`default_nettype wire

// File: design/cbf_cmdq.sv
// Command queue between the front end and the byte sequencer.
`default_nettype none

module cbf_cmdq #(
    parameter int DEPTH = cbf_pkg::CMDQ_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cbf_pkg::t_cmd       i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output cbf_pkg::t_cmd       o_cmd
);
    import cbf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

// File: design/cbf_back.sv
// Byte sequencer: expands commands into tape bytes behind an output register.
`default_nettype none

module cbf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  cbf_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_byte,
    output logic               o_last
);
    import cbf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSYNC,
        ST_HDR,
        ST_SYNC,
        ST_BLK,
        ST_FOOT,
        ST_DATA,
        ST_SUM
    } t_state;

    localparam logic [4:0] SYNC_END = 5'(SYNC_ONES + 1);
    localparam logic [4:0] HDR_END  = 5'd16;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    t_cmd       r_cmd, n_cmd;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       advance;
    logic       seg_end;
    logic       cur_last;
    logic [7:0] cur_byte;
    logic [3:0] nidx;

    assign o_empty = !r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;
    assign advance = (r_state != ST_IDLE) && (!r_out_valid || i_pop);
    assign nidx    = r_cnt[3:0] - 4'd2;

    always_comb begin
        cur_byte = 8'h00;
        cur_last = 1'b0;
        seg_end  = 1'b0;
        case (r_state)
            ST_HSYNC, ST_SYNC: begin
                if (r_cnt < 5'(SYNC_ONES)) begin
                    cur_byte = SYNC_ONE;
                end else if (r_cnt == 5'(SYNC_ONES)) begin
                    cur_byte = SYNC_A;
                end else begin
                    cur_byte = SYNC_B;
                end
                seg_end = (r_cnt == SYNC_END);
            end
            ST_HDR: begin
                if (r_cnt == 5'd0) begin
                    cur_byte = HDR_TYPE;
                end else if (r_cnt == 5'd1) begin
                    cur_byte = HDR_LEN;
                end else if (r_cnt inside {[5'd2:5'd12]}) begin
                    cur_byte = r_cmd.name[nidx];
                end else if (r_cnt == 5'd13) begin
                    cur_byte = TAIL_A;
                end else if (r_cnt == HDR_END) begin
                    cur_byte = r_cmd.chk;
                end else begin
                    cur_byte = TAIL_ZERO;
                end
                seg_end = (r_cnt == HDR_END);
            end
            ST_BLK: begin
                cur_byte = (r_cnt == 5'd0) ? BLK_TYPE : r_cmd.value;
                seg_end  = (r_cnt == 5'd1);
                cur_last = seg_end;
            end
            ST_FOOT: begin
                if (r_cnt == 5'd0) begin
                    cur_byte = FOOT_TYPE;
                end else if (r_cnt == 5'd1) begin
                    cur_byte = TAIL_A;
                end else begin
                    cur_byte = TAIL_ZERO;
                end
                seg_end  = (r_cnt == 5'd2);
                cur_last = seg_end;
            end
            ST_DATA: begin
                cur_byte = r_cmd.value;
                seg_end  = 1'b1;
                cur_last = !r_cmd.sum_flag;
            end
            ST_SUM: begin
                cur_byte = r_cmd.chk;
                seg_end  = 1'b1;
                cur_last = 1'b1;
            end
            default: begin
                cur_byte = 8'h00;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop) begin
            n_cmd = i_q_cmd;
            n_cnt = 5'd0;
            if (i_q_cmd.kind == KIND_DATA) begin
                n_state = ST_DATA;
            end else if (i_q_cmd.hdr) begin
                n_state = ST_HSYNC;
            end else begin
                n_state = ST_SYNC;
            end
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_last  = cur_last;
            if (seg_end) begin
                n_cnt = 5'd0;
                case (r_state)
                    ST_HSYNC: n_state = ST_HDR;
                    ST_HDR:   n_state = ST_SYNC;
                    ST_SYNC:  n_state = (r_cmd.kind == KIND_FOOT) ? ST_FOOT : ST_BLK;
                    ST_DATA:  n_state = r_cmd.sum_flag ? ST_SUM : ST_IDLE;
                    default:  n_state = ST_IDLE;
                endcase
            end else begin
                n_cnt = r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt <= SYNC_END))
        else $error("sequencer count out of range");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != ST_IDLE) && (r_cnt == 5'd0))
        else $error("command load did not start a sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_out_valid) |-> i_pop)
        else $error("output register overwritten while held");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cur_last) |=> (r_state == ST_IDLE))
        else $error("last byte emitted but sequencer still busy");
`endif

endmodule

`default_nettype wire

// File: design/cassette_block_framer.sv
// Top level of the cassette block framer: front end, command queue, byte sequencer.
//
// Input channel: i_opcode/i_value are taken on a rising edge with push high and
// full low. Name characters are stored; block starts, data bytes and end of file
// become commands in a two-entry queue. Out-of-order items are taken and dropped.
// Result channel: o_out_byte/o_run_last show the oldest byte while empty is low;
// pop takes it. o_run_last marks the last byte caused by one input transaction.
// Throughput: one byte per cycle from the sequencer while each byte is popped; it
// emits no byte while it loads a command. The last data byte of a block is followed
// by the checksum. A block start emits sync bytes and the block header, end of file
// sync bytes and the footer; the file header goes first on the first command of a file.
// A stalled result holds in the output register; the sequencer then stops, the
// queue fills and full rises.
// Reset (synchronous, active low) clears the name to spaces, the header flag,
// block counters, the queue and the output register.
`default_nettype none

module cassette_block_framer #(
    parameter int NAME_LEN  = cbf_pkg::NAME_LEN_DEF,
    parameter int BLOCK_MAX = cbf_pkg::BLOCK_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_value,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);
    import cbf_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    cbf_front #(
        .NAME_LEN  (NAME_LEN),
        .BLOCK_MAX (BLOCK_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_q_full   (q_full),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .o_full     (full),
        .o_cmd_push (q_push),
        .o_cmd      (f_cmd)
    );

    cbf_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    cbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_byte    (o_out_byte),
        .o_last    (o_run_last)
    );

endmodule

`default_nettype wire
